/* hw/rtl/atbs_pkg.sv */
// shared types, constants and the burst toggle table for the alarm sequencer
// no dependencies; every other file of the block imports this package
package atbs_pkg;

  localparam int PATTERN_POINTS_DEF = 21;
  localparam int LED_CHANNELS_DEF   = 5;

  // led flag channels carried by one tick: fio2 high/low, paw high/low, mute
  localparam int LED_FLAG_W   = 5;
  localparam int TONE_TICK_W  = 8;
  localparam int TONE_IDX_W   = 5;
  localparam int BLINK_TICK_W = 8;
  localparam int BLINK_PH_W   = 2;
  localparam int MUTE_W       = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam logic [BLINK_TICK_W-1:0] BLINK_HALF_RST = 8'd5;
  localparam logic [MUTE_W-1:0]       MUTE_TICKS_RST = 10'd600;
  // buzzer forced off at the point after which the tick count reaches this
  localparam int                      TONE_OFF_COUNT = 225;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLINK_HALF_PERIOD = 2'd0,
    CFG_MUTE_TICKS        = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic selftest_active;
    logic oxygen_cell_error;
    logic startup_done;
    logic calibrating;
    logic shutting_down;
    logic fio2_high;
    logic fio2_low;
    logic paw_high;
    logic paw_low;
    logic battery_red;
    logic mute_request;
  } in_t;

  typedef struct packed {
    logic buzzer;
    logic led_fio2_high;
    logic led_fio2_low;
    logic led_paw_high;
    logic led_paw_low;
    logic led_mute;
    logic muted;
    logic mute_expired;
  } out_t;

  // gating decision for one tick
  typedef struct packed {
    logic tone_open;
    logic muted;
    logic load_blink;
    logic shutdown;
  } gate_t;

  // 3+2 high-priority burst toggle points, undefined points read 255
  function automatic logic [TONE_TICK_W-1:0] tone_point(input logic [TONE_IDX_W-1:0] idx);
    logic [TONE_TICK_W-1:0] p;
    case (idx)
      5'd0:    p = 8'd0;
      5'd1:    p = 8'd4;
      5'd2:    p = 8'd6;
      5'd3:    p = 8'd10;
      5'd4:    p = 8'd12;
      5'd5:    p = 8'd16;
      5'd6:    p = 8'd22;
      5'd7:    p = 8'd26;
      5'd8:    p = 8'd28;
      5'd9:    p = 8'd32;
      5'd10:   p = 8'd52;
      5'd11:   p = 8'd56;
      5'd12:   p = 8'd58;
      5'd13:   p = 8'd62;
      5'd14:   p = 8'd64;
      5'd15:   p = 8'd68;
      5'd16:   p = 8'd74;
      5'd17:   p = 8'd78;
      5'd18:   p = 8'd80;
      5'd19:   p = 8'd84;
      5'd20:   p = 8'd224;
      default: p = 8'd255;
    endcase
    return p;
  endfunction

endpackage

/* hw/rtl/atbs_gate.sv */
// alarm gating: self test, startup, calibration, fault and shutdown qualify the tick
// depends on atbs_pkg
module atbs_gate (
  input  atbs_pkg::in_t                       tick_i,
  output atbs_pkg::gate_t                     gate_o,
  output logic [atbs_pkg::LED_FLAG_W-1:0]     flags_o
);
  import atbs_pkg::*;

  logic normal;

  assign normal  = !tick_i.oxygen_cell_error && tick_i.startup_done &&
                   !tick_i.calibrating && !tick_i.shutting_down;
  // outside normal operation every led arming is dropped
  assign flags_o = normal ? {tick_i.mute_request, tick_i.paw_low, tick_i.paw_high,
                             tick_i.fio2_low, tick_i.fio2_high} : '0;

  always_comb begin
    gate_o.shutdown = tick_i.shutting_down;
    if (tick_i.selftest_active) begin
      // self test leaves led arming alone
      gate_o.tone_open  = 1'b1;
      gate_o.muted      = 1'b0;
      gate_o.load_blink = 1'b0;
    end else if (normal) begin
      gate_o.tone_open  = tick_i.fio2_high || tick_i.fio2_low || tick_i.paw_high ||
                          tick_i.paw_low || tick_i.battery_red;
      gate_o.muted      = tick_i.mute_request;
      gate_o.load_blink = 1'b1;
    end else begin
      gate_o.tone_open  = 1'b0;
      gate_o.muted      = 1'b1;
      gate_o.load_blink = 1'b1;
    end
  end

endmodule

/* hw/rtl/atbs_tone.sv */
// buzzer burst player: walks the toggle table once per tick, mute abandons the burst
// depends on atbs_pkg
module atbs_tone #(
  parameter int PATTERN_POINTS = atbs_pkg::PATTERN_POINTS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_i,
  input  atbs_pkg::gate_t gate_i,
  output logic            buzzer_o
);
  import atbs_pkg::*;

  localparam logic [TONE_IDX_W:0] PTS = (TONE_IDX_W+1)'(PATTERN_POINTS);
  localparam logic [TONE_TICK_W-1:0] OFF_POINT = TONE_TICK_W'(TONE_OFF_COUNT - 1);

  logic                   running_r, running_nxt;
  logic [TONE_TICK_W-1:0] tick_r, tick_nxt;
  logic [TONE_IDX_W-1:0]  index_r, index_nxt;
  logic                   level_r, level_nxt;
  logic [TONE_IDX_W:0]    idx_inc;

  always_comb begin
    running_nxt = running_r;
    tick_nxt    = tick_r;
    index_nxt   = index_r;
    level_nxt   = level_r;
    idx_inc     = {1'b0, index_r} + 1'b1;
    if (!running_r && gate_i.tone_open) begin
      running_nxt = 1'b1;
      tick_nxt    = '0;
      index_nxt   = '0;
      level_nxt   = 1'b0;
      idx_inc     = (TONE_IDX_W+1)'(1);
    end
    if (running_nxt) begin
      if (gate_i.muted) begin
        level_nxt   = 1'b0;
        running_nxt = 1'b0;
      end else if ({1'b0, index_nxt} >= PTS) begin
        running_nxt = 1'b0;
      end else begin
        tick_nxt = tick_nxt + 1'b1;
        if ((tick_nxt - 1'b1) == tone_point(index_nxt)) begin
          level_nxt = ((tick_nxt - 1'b1) == OFF_POINT) ? 1'b0 : !level_nxt;
          index_nxt = idx_inc[TONE_IDX_W-1:0];
          if (idx_inc >= PTS) begin
            running_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      tick_r    <= '0;
      index_r   <= '0;
      level_r   <= 1'b0;
    end else if (step_i) begin
      running_r <= running_nxt;
      tick_r    <= tick_nxt;
      index_r   <= index_nxt;
      level_r   <= level_nxt;
    end
  end

  assign buzzer_o = level_nxt;

endmodule

/* hw/rtl/atbs_blink.sv */
// led blinkers: each armed channel gives one on/off cycle with a programmable half period
// depends on atbs_pkg
module atbs_blink #(
  parameter int LED_CHANNELS = atbs_pkg::LED_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_i,
  input  atbs_pkg::gate_t                   gate_i,
  input  logic [atbs_pkg::LED_FLAG_W-1:0]   flags_i,
  input  logic [atbs_pkg::BLINK_TICK_W-1:0] half_period_i,
  output logic [atbs_pkg::LED_FLAG_W-1:0]   leds_o
);
  import atbs_pkg::*;

  localparam int EXT_W = (LED_CHANNELS > LED_FLAG_W) ? LED_CHANNELS : LED_FLAG_W;

  logic                    open_r    [LED_CHANNELS];
  logic                    open_nxt  [LED_CHANNELS];
  logic                    run_r     [LED_CHANNELS];
  logic                    run_nxt   [LED_CHANNELS];
  logic [BLINK_TICK_W-1:0] tick_r    [LED_CHANNELS];
  logic [BLINK_TICK_W-1:0] tick_nxt  [LED_CHANNELS];
  logic [BLINK_PH_W-1:0]   phase_r   [LED_CHANNELS];
  logic [BLINK_PH_W-1:0]   phase_nxt [LED_CHANNELS];
  logic                    status_r  [LED_CHANNELS];
  logic                    status_nxt[LED_CHANNELS];
  logic [LED_CHANNELS-1:0] pin_r, pin_nxt;
  logic [EXT_W-1:0]        flag_ext, pin_ext;
  logic                    any_run;
  logic                    open_v, start;

  assign flag_ext = EXT_W'(flags_i);

  always_comb begin
    any_run = 1'b0;
    pin_nxt = pin_r;
    open_v  = 1'b0;
    start   = 1'b0;
    for (int ch = 0; ch < LED_CHANNELS; ch++) begin
      open_v         = gate_i.load_blink ? flag_ext[ch] : open_r[ch];
      start          = !run_r[ch] && open_v;
      open_nxt[ch]   = start ? 1'b0 : open_v;
      run_nxt[ch]    = run_r[ch] || start;
      tick_nxt[ch]   = start ? '0 : tick_r[ch];
      phase_nxt[ch]  = start ? '0 : phase_r[ch];
      status_nxt[ch] = start ? 1'b0 : status_r[ch];
      any_run        = any_run || run_nxt[ch];
      // shutdown freezes running blinkers
      if (run_nxt[ch] && !gate_i.shutdown) begin
        if (tick_nxt[ch] == half_period_i) begin
          tick_nxt[ch]   = '0;
          status_nxt[ch] = !status_nxt[ch];
          pin_nxt[ch]    = status_nxt[ch];
          phase_nxt[ch]  = phase_nxt[ch] + 1'b1;
          if (phase_nxt[ch][BLINK_PH_W-1]) begin
            run_nxt[ch] = 1'b0;
          end
        end else begin
          tick_nxt[ch] = tick_nxt[ch] + 1'b1;
        end
      end
    end
    // both fio2 pins go dark while any blinker is frozen by shutdown
    for (int ch = 0; ch < LED_CHANNELS; ch++) begin
      if (gate_i.shutdown && any_run && ch < 2) begin
        pin_nxt[ch] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_r <= '0;
      for (int ch = 0; ch < LED_CHANNELS; ch++) begin
        open_r[ch]   <= 1'b0;
        run_r[ch]    <= 1'b0;
        tick_r[ch]   <= '0;
        phase_r[ch]  <= '0;
        status_r[ch] <= 1'b0;
      end
    end else if (step_i) begin
      pin_r <= pin_nxt;
      for (int ch = 0; ch < LED_CHANNELS; ch++) begin
        open_r[ch]   <= open_nxt[ch];
        run_r[ch]    <= run_nxt[ch];
        tick_r[ch]   <= tick_nxt[ch];
        phase_r[ch]  <= phase_nxt[ch];
        status_r[ch] <= status_nxt[ch];
      end
    end
  end

  // absent channels read 0
  assign pin_ext = EXT_W'(pin_nxt);
  assign leds_o  = pin_ext[LED_FLAG_W-1:0];

endmodule

/* hw/rtl/atbs_mute.sv */
// mute timeout: counts down while sound is disabled, pulses expiry and reloads at zero
// depends on atbs_pkg
module atbs_mute (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_i,
  input  logic                        muted_i,
  input  logic [atbs_pkg::MUTE_W-1:0] mute_ticks_i,
  output logic                        expired_o
);
  import atbs_pkg::*;

  logic [MUTE_W-1:0] count_r, count_nxt;

  always_comb begin
    expired_o = 1'b0;
    if (!muted_i) begin
      count_nxt = mute_ticks_i;
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end else begin
      expired_o = 1'b1;
      count_nxt = mute_ticks_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= MUTE_TICKS_RST;
    end else if (step_i) begin
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/alarm_tone_and_blink_sequencer_unit.sv */
// high-priority alarm sequencer: one 50 ms tick in, one buzzer/led/mute result out
// the input register and the result register lie between input transfer and result
// transfer; throughput one tick per cycle while out_stall does not hold the result,
// set by the input register and result register around one pass of gating logic
// synchronous active-low reset clears all sequencer state, the mute countdown to 600
// and the registers to blink_half_period 5, mute_ticks 600; no warm-up after reset
// depends on atbs_pkg, atbs_gate, atbs_tone, atbs_blink, atbs_mute
module alarm_tone_and_blink_sequencer_unit #(
  parameter int PATTERN_POINTS = atbs_pkg::PATTERN_POINTS_DEF,
  parameter int LED_CHANNELS   = atbs_pkg::LED_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  atbs_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output atbs_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [atbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import atbs_pkg::*;

  logic                    in_valid_r;
  in_t                     in_data_r;
  logic                    out_valid_r;
  out_t                    out_data_r;
  logic [BLINK_TICK_W-1:0] blink_half_r;
  logic [MUTE_W-1:0]       mute_ticks_r;
  logic                    advance, step;
  gate_t                   gate;
  logic [LED_FLAG_W-1:0]   flags;
  logic [LED_FLAG_W-1:0]   leds;
  logic                    buzzer, expired;
  out_t                    result;

  assign advance   = !(out_valid_r && out_stall);
  assign step      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_half_r <= BLINK_HALF_RST;
      mute_ticks_r <= MUTE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BLINK_HALF_PERIOD: blink_half_r <= cfg_data[BLINK_TICK_W-1:0];
        CFG_MUTE_TICKS:        mute_ticks_r <= cfg_data[MUTE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register takes a transfer whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  atbs_gate u_gate (
    .tick_i  (in_data_r),
    .gate_o  (gate),
    .flags_o (flags)
  );

  atbs_tone #(
    .PATTERN_POINTS (PATTERN_POINTS)
  ) u_tone (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .gate_i   (gate),
    .buzzer_o (buzzer)
  );

  atbs_blink #(
    .LED_CHANNELS (LED_CHANNELS)
  ) u_blink (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .gate_i        (gate),
    .flags_i       (flags),
    .half_period_i (blink_half_r),
    .leds_o        (leds)
  );

  atbs_mute u_mute (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_i       (step),
    .muted_i      (gate.muted),
    .mute_ticks_i (mute_ticks_r),
    .expired_o    (expired)
  );

  always_comb begin
    result.buzzer        = buzzer;
    result.led_fio2_high = leds[0];
    result.led_fio2_low  = leds[1];
    result.led_paw_high  = leds[2];
    result.led_paw_low   = leds[3];
    result.led_mute      = leds[4];
    result.muted         = gate.muted;
    result.mute_expired  = expired;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an expiry pulse only comes while sound is disabled
  a_expired_muted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.mute_expired |-> out_data_r.muted)
    else $error("mute expiry without mute");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a waiting result");

  // every processed tick shows up as a result on the next cycle
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("processed tick lost its result");

endmodule
